// File: rtl/core/cyk_pkg.sv
// ----------------------------------------------------------------------------
// cyk_pkg: shared types and constants of the CYK recognizer
// Grammar sizes, register codes, beat structs and the sequencer states.
// ----------------------------------------------------------------------------
package cyk_pkg;

    localparam int MAX_WORDS        = 32;
    localparam int NONTERMINALS     = 8;
    localparam int RULE_SLOTS       = 24;
    localparam int TERMINAL_CLASSES = 4;

    localparam int SLOT_W         = 10;
    localparam int SLOTS_PER_WORD = 6;
    localparam int RULE_WORDS     = 4;
    localparam int RULE_W         = SLOT_W * SLOTS_PER_WORD;
    localparam int SET_W          = 8;
    localparam int CLASS_W        = 2;
    localparam int SYM_W          = 3;

    localparam int W_IDX  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int W_CNT  = $clog2(MAX_WORDS + 1);
    localparam int W_ADDR = 2 * W_IDX;
    localparam int W_INF  = $clog2(RULE_SLOTS + 4);

    localparam logic [SET_W-1:0] SET_MASK = SET_W'((1 << NONTERMINALS) - 1);

    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    localparam logic [2:0] REG_RULE0 = 3'd0;
    localparam logic [2:0] REG_RULE1 = 3'd1;
    localparam logic [2:0] REG_RULE2 = 3'd2;
    localparam logic [2:0] REG_RULE3 = 3'd3;
    localparam logic [2:0] REG_TMAP  = 3'd4;
    localparam logic [2:0] REG_START = 3'd5;

    typedef struct packed {
        logic [CLASS_W-1:0] word_class;
        logic               last_word;
    } t_item;

    typedef struct packed {
        logic             accepted;
        logic [SET_W-1:0] top_set;
        logic             too_long;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [SET_W-1:0] lft;
        logic [SET_W-1:0] rgt;
        logic [SET_W-1:0] acc;
    } t_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// File: rtl/core/cyk_rule_cell.sv
// ----------------------------------------------------------------------------
// cyk_rule_cell: one binary rule stage
// Tests its rule against the passing pair and adds the lhs to the beat.
// ----------------------------------------------------------------------------
module cyk_rule_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cyk_pkg::SLOT_W-1:0]    i_rule,
    input  cyk_pkg::t_beat                i_beat,
    output cyk_pkg::t_beat                o_beat
);
    import cyk_pkg::*;

    t_beat            r_beat;
    t_beat            n_beat;
    logic             hit;
    logic [SET_W-1:0] lhs_bit;

    always_comb begin
        hit     = i_rule[9] & i_beat.lft[i_rule[5:3]] & i_beat.rgt[i_rule[2:0]];
        lhs_bit = SET_W'(1) << i_rule[8:6];
        n_beat  = i_beat;
        if (hit) begin
            n_beat.acc = (i_beat.acc | lhs_bit) & SET_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.lft <= n_beat.lft;
        r_beat.rgt <= n_beat.rgt;
        r_beat.acc <= n_beat.acc;
    end

    assign o_beat = r_beat;

endmodule

// File: rtl/core/cyk_rule_chain.sv
// ----------------------------------------------------------------------------
// cyk_rule_chain: row of rule cells
// A cell set pair walks one rule slot per cycle and leaves with its union.
// ----------------------------------------------------------------------------
module cyk_rule_chain (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [cyk_pkg::RULE_W-1:0] i_rule_words [cyk_pkg::RULE_WORDS],
    input  cyk_pkg::t_beat             i_beat,
    output cyk_pkg::t_beat             o_beat
);
    import cyk_pkg::*;

    t_beat link [RULE_SLOTS+1];

    assign link[0] = i_beat;

    for (genvar s = 0; s < RULE_SLOTS; s++) begin : g_cell
        cyk_rule_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rule  (i_rule_words[s / SLOTS_PER_WORD]
                                  [SLOT_W*(s % SLOTS_PER_WORD) +: SLOT_W]),
            .i_beat  (link[s]),
            .o_beat  (link[s+1])
        );
    end

    assign o_beat = link[RULE_SLOTS];

endmodule

// File: rtl/core/cyk_cnf_recognizer_core.sv
// ----------------------------------------------------------------------------
// cyk_cnf_recognizer_core: CYK recognizer for a grammar in Chomsky normal form
// Word j of a sentence (counting from 0) raises busy for one cycle when j is 0.
// Otherwise it fills rows r = j-1 down to 0 of its column. Each row issues its
// table reads in S_ISSUE, then waits in S_DRAIN until the read register and the
// rule cell chain are empty; S_DONE closes the word. The result comes in the
// cycle after S_DONE of the final word, on o_result_valid for one cycle; the
// receiver cannot stall it. A word beyond MAX_WORDS is dropped without raising
// busy; if it is final, its result comes in the next cycle. The table memory
// needs no clearing after reset.
// ----------------------------------------------------------------------------
module cyk_cnf_recognizer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cyk_pkg::t_item              i_item,
    output logic                        o_result_valid,
    output cyk_pkg::t_result            o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cyk_pkg::PADDR_W-1:0] paddr,
    input  logic [cyk_pkg::PDATA_W-1:0] pwdata,
    output logic [cyk_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import cyk_pkg::*;

    logic [RULE_W-1:0] r_rule [RULE_WORDS];
    logic [31:0]       r_tmap;
    logic [SYM_W-1:0]  r_start;
    logic [2:0]        reg_idx;

    t_state            r_state, n_state;
    logic [W_CNT-1:0]  r_wcnt, n_wcnt;
    logic              r_ovf, n_ovf;
    logic [W_IDX-1:0]  r_j, n_j;
    logic [W_IDX-1:0]  r_row, n_row;
    logic [W_IDX-1:0]  r_l, n_l;
    logic              r_last, n_last;
    logic [SET_W-1:0]  r_acc, n_acc;
    logic [SET_W-1:0]  r_top, n_top;
    logic [W_INF-1:0]  r_inflight, n_inflight;
    logic              r_res_valid, n_res_valid;
    t_result           r_res, n_res;

    logic [SET_W-1:0]  mem [1 << W_ADDR];
    logic              we;
    logic [W_ADDR-1:0] waddr;
    logic [SET_W-1:0]  wdata;
    logic              issue;
    logic [W_ADDR-1:0] raddr_a, raddr_b;
    logic [SET_W-1:0]  r_rd_a, r_rd_b;
    logic              r_rd_valid;

    logic [W_IDX-1:0]  jidx;
    logic [SET_W-1:0]  diag;
    t_beat             chain_in, chain_out;

    // configuration port
    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RULE_WORDS; k++) begin
                r_rule[k] <= '0;
            end
            r_tmap  <= '0;
            r_start <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_RULE0: r_rule[0] <= pwdata[RULE_W-1:0];
                REG_RULE1: r_rule[1] <= pwdata[RULE_W-1:0];
                REG_RULE2: r_rule[2] <= pwdata[RULE_W-1:0];
                REG_RULE3: r_rule[3] <= pwdata[RULE_W-1:0];
                REG_TMAP:  r_tmap    <= pwdata[31:0];
                REG_START: r_start   <= pwdata[SYM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RULE0: prdata = PDATA_W'(r_rule[0]);
            REG_RULE1: prdata = PDATA_W'(r_rule[1]);
            REG_RULE2: prdata = PDATA_W'(r_rule[2]);
            REG_RULE3: prdata = PDATA_W'(r_rule[3]);
            REG_TMAP:  prdata = PDATA_W'(r_tmap);
            REG_START: prdata = PDATA_W'(r_start);
            default:   prdata = '0;
        endcase
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (issue) begin
            r_rd_a <= mem[raddr_a];
            r_rd_b <= mem[raddr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= issue;
        end
    end

    assign chain_in = '{valid: r_rd_valid, lft: r_rd_a, rgt: r_rd_b, acc: '0};

    cyk_rule_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rule_words (r_rule),
        .i_beat       (chain_in),
        .o_beat       (chain_out)
    );

    // sequencer
    assign jidx = r_wcnt[W_IDX-1:0];
    assign busy = (r_state != S_IDLE);

    always_comb begin
        if (32'(i_item.word_class) < TERMINAL_CLASSES) begin
            diag = r_tmap[{i_item.word_class, 3'b000} +: SET_W] & SET_MASK;
        end else begin
            diag = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wcnt      = r_wcnt;
        n_ovf       = r_ovf;
        n_j         = r_j;
        n_row       = r_row;
        n_l         = r_l;
        n_last      = r_last;
        n_top       = r_top;
        n_acc       = r_acc | (chain_out.valid ? chain_out.acc : '0);
        n_res_valid = 1'b0;
        n_res       = r_res;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        issue       = 1'b0;
        raddr_a     = {r_row, r_l};
        raddr_b     = {W_IDX'(r_l + 1'b1), r_j};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (32'(r_wcnt) >= MAX_WORDS) begin
                        n_ovf = 1'b1;
                        if (i_item.last_word) begin
                            n_res_valid = 1'b1;
                            n_res       = '{accepted: 1'b0, top_set: '0, too_long: 1'b1};
                            n_wcnt      = '0;
                            n_ovf       = 1'b0;
                        end
                    end else begin
                        we     = 1'b1;
                        waddr  = {jidx, jidx};
                        wdata  = diag;
                        n_j    = jidx;
                        n_wcnt = W_CNT'(r_wcnt + 1'b1);
                        n_last = i_item.last_word;
                        n_top  = diag;
                        n_acc  = '0;
                        if (jidx == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_row   = W_IDX'(jidx - 1'b1);
                            n_l     = W_IDX'(jidx - 1'b1);
                            n_state = S_ISSUE;
                        end
                    end
                end
            end
            S_ISSUE: begin
                issue = 1'b1;
                if (r_l == W_IDX'(r_j - 1'b1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_l = W_IDX'(r_l + 1'b1);
                end
            end
            S_DRAIN: begin
                if (r_inflight == '0) begin
                    we    = 1'b1;
                    waddr = {r_row, r_j};
                    wdata = r_acc;
                    n_top = r_acc;
                    n_acc = '0;
                    if (r_row == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_row   = W_IDX'(r_row - 1'b1);
                        n_l     = W_IDX'(r_row - 1'b1);
                        n_state = S_ISSUE;
                    end
                end
            end
            S_DONE: begin
                if (r_last) begin
                    n_res_valid = 1'b1;
                    n_res       = '{accepted: r_top[r_start], top_set: r_top,
                                    too_long: 1'b0};
                    n_wcnt      = '0;
                    n_ovf       = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_inflight = W_INF'(r_inflight + W_INF'(issue) - W_INF'(chain_out.valid));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wcnt      <= '0;
            r_ovf       <= 1'b0;
            r_inflight  <= '0;
            r_res_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wcnt      <= n_wcnt;
            r_ovf       <= n_ovf;
            r_inflight  <= n_inflight;
            r_res_valid <= n_res_valid;
            r_last      <= n_last;
        end
        r_j   <= n_j;
        r_row <= n_row;
        r_l   <= n_l;
        r_acc <= n_acc;
        r_top <= n_top;
        r_res <= n_res;
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

// File: rtl/core/cyk_checker.sv
// ----------------------------------------------------------------------------
// cyk_checker: port-level checks of the CYK recognizer
// Watches result beats against the item handshake and the config port.
// ----------------------------------------------------------------------------
module cyk_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input cyk_pkg::t_item              i_item,
    input logic                        o_result_valid,
    input cyk_pkg::t_result            o_result,
    input logic                        pready
);
    import cyk_pkg::*;

    a_no_result_mid_sentence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_item.last_word) |=> !o_result_valid)
        else $error("result beat after a non-final word");

    a_overflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.too_long) |-> (o_result.top_set == '0))
        else $error("overflow beat carries a top set");

    a_accept_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.accepted) |-> (o_result.top_set != '0))
        else $error("accepted with an empty top set");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind cyk_cnf_recognizer_core cyk_checker u_cyk_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_item         (i_item),
    .o_result_valid (o_result_valid),
    .o_result       (o_result),
    .pready         (pready)
);

// File: tb/cyk_cnf_recognizer_checker.sv
// ----------------------------------------------------------------------------
// cyk_cnf_recognizer_checker: parse-table predictor and result scoreboard
// Tracks register writes on the APB port and word beats on the command
// channel. It rebuilds the CYK table column by column for each accepted word,
// and it queues the verdict of each final word. Each result strobe is then
// compared field by field with the oldest queued verdict.
// ----------------------------------------------------------------------------
module cyk_cnf_recognizer_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  cyk_pkg::t_item               i_item,
    input  logic                         i_result_valid,
    input  cyk_pkg::t_result             i_result,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [cyk_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [cyk_pkg::PDATA_W-1:0]  i_pwdata,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_results,
    output int                           o_accepts,
    output int                           o_overflows
);
    import cyk_pkg::*;

    logic [RULE_W-1:0] grammar_rules [RULE_WORDS];
    logic [31:0]       class_map;
    logic [SYM_W-1:0]  goal_sym;
    logic [SET_W-1:0]  parse_table [MAX_WORDS][MAX_WORDS];
    int                words_held;
    logic              overflowed;
    t_result           verdicts [$];

    function automatic logic [SET_W-1:0] apply_rules(logic [SET_W-1:0] lset,
                                                     logic [SET_W-1:0] rset);
        logic [SET_W-1:0] sum;
        logic [SLOT_W-1:0] slot;
        sum = '0;
        for (int s = 0; s < RULE_SLOTS; s++) begin
            slot = grammar_rules[s / SLOTS_PER_WORD][SLOT_W * (s % SLOTS_PER_WORD) +: SLOT_W];
            if (slot[9] && lset[slot[5:3]] && rset[slot[2:0]])
                sum[slot[8:6]] = 1'b1;
        end
        return sum & SET_MASK;
    endfunction

    task automatic take_word(t_item w);
        logic [SET_W-1:0] part_set;
        t_result v;
        int j;
        if (words_held >= MAX_WORDS) begin
            overflowed = 1'b1;
        end else begin
            j = words_held;
            part_set = '0;
            if (int'(w.word_class) < TERMINAL_CLASSES)
                part_set = class_map[8 * w.word_class +: 8] & SET_MASK;
            parse_table[j][j] = part_set;
            for (int row = j - 1; row >= 0; row--) begin
                part_set = '0;
                for (int l = row; l < j; l++)
                    part_set |= apply_rules(parse_table[row][l], parse_table[l + 1][j]);
                parse_table[row][j] = part_set;
            end
            words_held++;
        end
        if (w.last_word) begin
            v = '0;
            if (overflowed) begin
                v.too_long = 1'b1;
            end else begin
                v.top_set  = parse_table[0][words_held - 1] & SET_MASK;
                v.accepted = (int'(goal_sym) < NONTERMINALS) ? v.top_set[goal_sym] : 1'b0;
            end
            verdicts.push_back(v);
            words_held = 0;
            overflowed = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_v;
        if (!i_rst_n) begin
            for (int k = 0; k < RULE_WORDS; k++)
                grammar_rules[k] = '0;
            class_map   = '0;
            goal_sym    = '0;
            words_held  = 0;
            overflowed  = 1'b0;
            verdicts.delete();
            o_errors    = 0;
            o_results   = 0;
            o_accepts   = 0;
            o_overflows = 0;
            o_pending   = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[5:3])
                    REG_RULE0, REG_RULE1, REG_RULE2, REG_RULE3:
                        grammar_rules[i_paddr[4:3]] = i_pwdata[RULE_W-1:0];
                    REG_TMAP:  class_map = i_pwdata[31:0];
                    REG_START: goal_sym  = i_pwdata[SYM_W-1:0];
                    default: ;
                endcase
            end
            if (i_result_valid) begin
                o_results++;
                if (verdicts.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result %p", $time, i_result);
                end else begin
                    exp_v = verdicts.pop_front();
                    if (i_result.accepted !== exp_v.accepted ||
                        i_result.top_set !== exp_v.top_set ||
                        i_result.too_long !== exp_v.too_long) begin
                        o_errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, exp_v, i_result);
                    end
                    if (exp_v.accepted) o_accepts++;
                    if (exp_v.too_long) o_overflows++;
                end
            end
            if (i_start && !i_busy)
                take_word(i_item);
            o_pending = verdicts.size();
        end
    end

endmodule

// File: tb/tb_cyk_cnf_recognizer_core.sv
// ----------------------------------------------------------------------------
// tb_cyk_cnf_recognizer_core: stimulus and verdict for the CYK recognizer
// Uses the empty reset grammar, loads over APB small English, all-ones and
// random ones, sends directed and random sentences including full-length and
// overflowing ones, with varying sender gaps, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_cyk_cnf_recognizer_core;
    import cyk_pkg::*;

    localparam int LIMIT  = 3000000;
    localparam int SETTLE = 800;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_item               i_item;
    logic                o_result_valid;
    t_result             o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int errors;
    int pending;
    int results;
    int accepts;
    int overflows;
    int cycles = 0;
    int words_sent;
    int gap_pct;

    cyk_cnf_recognizer_core dut (.*);

    cyk_cnf_recognizer_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_results      (results),
        .o_accepts      (accepts),
        .o_overflows    (overflows)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [SLOT_W-1:0] rule(int lhs, int lft, int rgt);
        return {1'b1, 3'(lhs), 3'(lft), 3'(rgt)};
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [PDATA_W-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 3'b000});
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_grammar(logic [RULE_W-1:0] r0, logic [RULE_W-1:0] r1,
                                logic [RULE_W-1:0] r2, logic [RULE_W-1:0] r3,
                                logic [31:0] tmap, logic [SYM_W-1:0] goal);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        reg_write(REG_RULE0, PDATA_W'(r0));
        reg_write(REG_RULE1, PDATA_W'(r1));
        reg_write(REG_RULE2, PDATA_W'(r2));
        reg_write(REG_RULE3, PDATA_W'(r3));
        reg_write(REG_TMAP, PDATA_W'(tmap));
        reg_write(REG_START, PDATA_W'(goal));
        reg_write(3'd6, {$urandom, $urandom});
        reg_write(3'd7, {$urandom, $urandom});
    endtask

    task automatic send_word(logic [CLASS_W-1:0] cls, logic fin);
        while ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start       = 1'b1;
        i_item      = '{word_class: cls, last_word: fin};
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        start = 1'b0;
        words_sent++;
    endtask

    task automatic send_random_sentence(int len);
        for (int k = 0; k < len; k++)
            send_word(CLASS_W'($urandom), k == len - 1);
    endtask

    // noun 0, verb 1, preposition 2, determiner 3
    task automatic send_np(logic fin);
        if ($urandom_range(1)) send_word(2'd3, 1'b0);
        send_word(2'd0, fin);
    endtask

    task automatic send_wellformed();
        int pps;
        pps = $urandom_range(3);
        send_np(1'b0);
        send_word(2'd1, 1'b0);
        send_np(pps == 0);
        for (int k = 0; k < pps; k++) begin
            send_word(2'd2, 1'b0);
            send_np(k == pps - 1);
        end
    endtask

    function automatic int pick_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 90) return $urandom_range(8, 1);
        if (roll < 98) return $urandom_range(31, 9);
        return $urandom_range(MAX_WORDS + 4, MAX_WORDS);
    endfunction

    task automatic random_phase(int quota, int gap, bit grammar_like);
        int target;
        target  = words_sent + quota;
        gap_pct = gap;
        while (words_sent < target) begin
            if (grammar_like && $urandom_range(99) < 70)
                send_wellformed();
            else
                send_random_sentence(pick_len());
            if ($urandom_range(99) < 10)
                while (pending != 0) @(negedge i_clk);
        end
    endtask

    logic [RULE_W-1:0] eng_rules0;
    logic [31:0]       eng_map;

    initial begin
        words_sent = 0;
        gap_pct    = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty grammar after reset
        for (int c = 0; c < 4; c++)
            send_word(CLASS_W'(c), 1'b1);
        send_random_sentence(MAX_WORDS + 1);

        // S0 NP1 VP2 PP3 N4 V5 P6 D7
        eng_rules0 = {rule(3, 6, 1), rule(2, 2, 3), rule(2, 5, 1),
                      rule(1, 1, 3), rule(1, 7, 4), rule(0, 1, 2)};
        eng_map    = 32'h80_40_24_12;
        load_grammar(eng_rules0, '0, '0, '0, eng_map, 3'd0);
        for (int c = 0; c < 4; c++)
            send_word(CLASS_W'(c), 1'b1);
        send_word(2'd3, 1'b0); send_word(2'd0, 1'b0); send_word(2'd1, 1'b0);
        send_word(2'd3, 1'b0); send_word(2'd0, 1'b1);
        send_word(2'd0, 1'b0); send_word(2'd1, 1'b0); send_word(2'd0, 1'b0);
        send_word(2'd2, 1'b0); send_word(2'd3, 1'b0); send_word(2'd0, 1'b1);
        send_random_sentence(MAX_WORDS);
        send_random_sentence(MAX_WORDS + 2);
        random_phase(250, 0, 1'b1);
        random_phase(250, 59, 1'b1);
        random_phase(150, 26, 1'b1);

        load_grammar({RULE_W{1'b1}}, {RULE_W{1'b1}}, {RULE_W{1'b1}}, {RULE_W{1'b1}},
                     32'hFFFF_FFFF, 3'd7);
        random_phase(200, 26, 1'b0);

        for (int p = 0; p < 3; p++) begin
            load_grammar({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom},
                         $urandom, SYM_W'($urandom));
            random_phase(220, (p == 1) ? 59 : 0, 1'b0);
        end

        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("Sent %0d words; checked %0d sentence verdicts (%0d accepted, %0d too long)",
                 words_sent, results, accepts, overflows);
        $display("Grammars: empty, small English, all ones, three random");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/cyk_pkg.sv
rtl/core/cyk_rule_cell.sv
rtl/core/cyk_rule_chain.sv
rtl/core/cyk_cnf_recognizer_core.sv
rtl/core/cyk_checker.sv
tb/cyk_cnf_recognizer_checker.sv
tb/tb_cyk_cnf_recognizer_core.sv
